FILE: src/dual_motor_command_ramp_kick_core_assert.svh
// Assertion macros shared by the motor command block's modules.
`ifndef DUAL_MOTOR_COMMAND_RAMP_KICK_CORE_ASSERT_SVH
`define DUAL_MOTOR_COMMAND_RAMP_KICK_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DMCRK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DMCRK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dmcrk_pkg.sv
// Shared constants, codes and types of the motor command block.
package dmcrk_pkg;

  localparam int DUTY_MAX   = 255;
  localparam int TIMER_BITS = 16;
  localparam int DUTY_W     = $clog2(DUTY_MAX + 1);
  localparam int VAL_W      = DUTY_W + 1;
  localparam int IN_W       = 11;
  localparam int SUM_W      = IN_W + 1;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_TANK     = 3'd1,
    FUNC_TWIST    = 3'd2,
    FUNC_LEFT     = 3'd3,
    FUNC_RIGHT    = 3'd4,
    FUNC_STOP     = 3'd5,
    FUNC_ENABLE   = 3'd6,
    FUNC_DISABLE  = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    REG_RAMP_STEP  = 2'd0,
    REG_KICK_DUTY  = 2'd1,
    REG_KICK_TICKS = 2'd2,
    REG_NONE       = 2'd3
  } reg_e;

  // Classified command: saturated left and right values.
  typedef struct packed {
    func_e                   op;
    logic signed [VAL_W-1:0] val_l;
    logic signed [VAL_W-1:0] val_r;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0]     ramp_step;
    logic [DUTY_W-1:0]     kick_duty;
    logic [TIMER_BITS-1:0] kick_ticks;
  } cfg_t;

endpackage

FILE: src/dmcrk_cfg.sv
// APB register file: ramp step, kick duty and kick length.
module dmcrk_cfg
  import dmcrk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t  cfg_q;
  cfg_t  cfg_d;
  reg_e  sel;
  logic  wr_en;

  assign sel    = reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_RAMP_STEP: begin
          // a zero step would stall ramping; store it as one
          cfg_d.ramp_step = (pwdata[DUTY_W-1:0] == '0) ? DUTY_W'(1) : pwdata[DUTY_W-1:0];
        end
        REG_KICK_DUTY:  cfg_d.kick_duty  = pwdata[DUTY_W-1:0];
        REG_KICK_TICKS: cfg_d.kick_ticks = pwdata[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_RAMP_STEP:  prdata = 32'(cfg_q.ramp_step);
      REG_KICK_DUTY:  prdata = 32'(cfg_q.kick_duty);
      REG_KICK_TICKS: prdata = 32'(cfg_q.kick_ticks);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_step  <= DUTY_W'(DUTY_MAX);
      cfg_q.kick_duty  <= '0;
      cfg_q.kick_ticks <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/dmcrk_front.sv
// Front end: takes requests, decodes the function and saturates the values.
module dmcrk_front
  import dmcrk_pkg::*;
(
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             func_i,
  input  logic signed [IN_W-1:0] value_a_i,
  input  logic signed [IN_W-1:0] value_b_i,
  input  logic                   fifo_full_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  localparam logic signed [SUM_W-1:0] SatHi = SUM_W'(DUTY_MAX);
  localparam logic signed [SUM_W-1:0] SatLo = -SatHi;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > SatHi) r = SatHi;
    if (v < SatLo) r = SatLo;
    return r[VAL_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;
  func_e                   op;

  assign a_ext = SUM_W'(value_a_i);
  assign b_ext = SUM_W'(value_b_i);
  assign op    = func_e'(func_i);

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    cmd_o.op    = op;
    cmd_o.val_l = '0;
    cmd_o.val_r = '0;
    case (op)
      FUNC_TANK: begin
        cmd_o.val_l = sat_val(a_ext);
        cmd_o.val_r = sat_val(b_ext);
      end
      FUNC_TWIST: begin
        cmd_o.val_l = sat_val(a_ext - b_ext);
        cmd_o.val_r = sat_val(a_ext + b_ext);
      end
      FUNC_LEFT:  cmd_o.val_l = sat_val(a_ext);
      // right target travels on the right lane
      FUNC_RIGHT: cmd_o.val_r = sat_val(a_ext);
      default: ;
    endcase
  end

endmodule

FILE: src/dmcrk_fifo.sv
// Short command queue between the front and back ends.
module dmcrk_fifo
  import dmcrk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`include "dual_motor_command_ramp_kick_core_assert.svh"

  `DMCRK_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "push into full queue")
  `DMCRK_ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o, "pop from empty queue")
  `DMCRK_ASSERT_IMPL(a_ptr_match, empty_o || full_o, wr_ptr_q == rd_ptr_q, "queue pointers out of step")

endmodule

FILE: src/dmcrk_back.sv
// Back end: channel state, ramping, kick timers and the result register.
module dmcrk_back
  import dmcrk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              fifo_empty_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DUTY_W-1:0] left_duty_o,
  output logic              left_forward_o,
  output logic [DUTY_W-1:0] right_duty_o,
  output logic              right_forward_o,
  output logic              standby_release_o,
  output logic              running_o,
  output logic              left_kicking_o,
  output logic              right_kicking_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] goal;
    logic signed [VAL_W-1:0] now;
    logic                    armed;
    logic [TIMER_BITS-1:0]   rem;
    logic [DUTY_W-1:0]       duty;
    logic                    fwd;
  } chan_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              fwd;
    logic              armed;
  } drv_t;

  function automatic logic signed [VAL_W-1:0] ramp_toward(
    input logic signed [VAL_W-1:0] cur,
    input logic signed [VAL_W-1:0] goal,
    input logic [DUTY_W-1:0]       step
  );
    logic signed [VAL_W:0] diff;
    logic signed [VAL_W:0] mag;
    logic signed [VAL_W:0] stp;
    logic signed [VAL_W:0] nxt;
    diff = (VAL_W+1)'(goal) - (VAL_W+1)'(cur);
    mag  = (diff < 0) ? -diff : diff;
    stp  = (VAL_W+1)'({1'b0, step});
    nxt  = (diff > 0) ? (VAL_W+1)'(cur) + stp : (VAL_W+1)'(cur) - stp;
    if (mag <= stp) return goal;
    return nxt[VAL_W-1:0];
  endfunction

  function automatic drv_t drive(
    input logic signed [VAL_W-1:0] now,
    input logic                    armed,
    input logic                    rem_zero,
    input logic [DUTY_W-1:0]       kd,
    input logic                    fwd_old
  );
    drv_t                    r;
    logic signed [VAL_W-1:0] m;
    m       = (now < 0) ? -now : now;
    r.duty  = m[DUTY_W-1:0];
    r.fwd   = fwd_old;
    r.armed = armed;
    if (now == '0) begin
      r.duty = '0;
    end else begin
      if (armed && rem_zero) begin
        r.armed = 1'b0;
      end else if (armed && (m[DUTY_W-1:0] < kd)) begin
        // lift a small duty while the kick runs
        r.duty = kd;
      end
      r.fwd = (now > 0);
    end
    return r;
  endfunction

  chan_t left_q, left_d;
  chan_t right_q, right_d;
  logic  run_q, run_d;
  logic  stby_q, stby_d;
  logic  out_valid_q;

  logic [DUTY_W-1:0] left_duty_q, right_duty_q;
  logic              left_fwd_q, right_fwd_q;
  logic              stby_out_q, run_out_q, left_kick_q, right_kick_q;

  drv_t  drv_l, drv_r;
  chan_t pre_l, pre_r;
  logic  arm_l, arm_r;

  assign pop_o = !fifo_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    run_d   = run_q;
    stby_d  = stby_q;
    pre_l   = left_q;
    pre_r   = right_q;
    arm_l   = (left_q.now == '0) && (cmd_i.val_l != '0);
    arm_r   = (right_q.now == '0) && (cmd_i.val_r != '0);

    if (cmd_i.op == FUNC_TICK) begin
      pre_l.rem = left_q.rem - TIMER_BITS'(left_q.rem != '0);
      pre_r.rem = right_q.rem - TIMER_BITS'(right_q.rem != '0);
      pre_l.now = ramp_toward(left_q.now, left_q.goal, cfg_i.ramp_step);
      pre_r.now = ramp_toward(right_q.now, right_q.goal, cfg_i.ramp_step);
    end else begin
      pre_l.goal = cmd_i.val_l;
      pre_r.goal = cmd_i.val_r;
      pre_l.now  = cmd_i.val_l;
      pre_r.now  = cmd_i.val_r;
      if (arm_l) begin
        pre_l.armed = 1'b1;
        pre_l.rem   = cfg_i.kick_ticks;
      end
      if (arm_r) begin
        pre_r.armed = 1'b1;
        pre_r.rem   = cfg_i.kick_ticks;
      end
    end

    drv_l = drive(pre_l.now, pre_l.armed, pre_l.rem == '0, cfg_i.kick_duty, pre_l.fwd);
    drv_r = drive(pre_r.now, pre_r.armed, pre_r.rem == '0, cfg_i.kick_duty, pre_r.fwd);

    if (pop_o) begin
      case (cmd_i.op)
        FUNC_TICK: begin
          left_d.rem  = pre_l.rem;
          right_d.rem = pre_r.rem;
          if (run_q) begin
            left_d.now    = pre_l.now;
            right_d.now   = pre_r.now;
            left_d.duty   = drv_l.duty;
            left_d.fwd    = drv_l.fwd;
            left_d.armed  = drv_l.armed;
            right_d.duty  = drv_r.duty;
            right_d.fwd   = drv_r.fwd;
            right_d.armed = drv_r.armed;
          end
        end
        FUNC_TANK, FUNC_TWIST: begin
          run_d = 1'b1;
          left_d  = pre_l;
          right_d = pre_r;
          left_d.duty   = drv_l.duty;
          left_d.fwd    = drv_l.fwd;
          left_d.armed  = drv_l.armed;
          right_d.duty  = drv_r.duty;
          right_d.fwd   = drv_r.fwd;
          right_d.armed = drv_r.armed;
        end
        FUNC_LEFT:  left_d.goal  = cmd_i.val_l;
        FUNC_RIGHT: right_d.goal = cmd_i.val_r;
        FUNC_ENABLE: begin
          stby_d = 1'b1;
          run_d  = 1'b1;
        end
        default: begin
          // stop and disable: drop goals, positions and duties
          left_d.goal  = '0;
          left_d.now   = '0;
          left_d.duty  = '0;
          right_d.goal = '0;
          right_d.now  = '0;
          right_d.duty = '0;
          run_d        = 1'b0;
          if (cmd_i.op == FUNC_DISABLE) begin
            stby_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '{goal: '0, now: '0, armed: 1'b0, rem: '0, duty: '0, fwd: 1'b1};
      right_q     <= '{goal: '0, now: '0, armed: 1'b0, rem: '0, duty: '0, fwd: 1'b1};
      run_q       <= 1'b0;
      stby_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
      run_q   <= run_d;
      stby_q  <= stby_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register: load the pin state each command leaves behind
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_duty_q  <= left_d.duty;
      left_fwd_q   <= left_d.fwd;
      right_duty_q <= right_d.duty;
      right_fwd_q  <= right_d.fwd;
      stby_out_q   <= stby_d;
      run_out_q    <= run_d;
      left_kick_q  <= left_d.armed;
      right_kick_q <= right_d.armed;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign left_duty_o       = left_duty_q;
  assign left_forward_o    = left_fwd_q;
  assign right_duty_o      = right_duty_q;
  assign right_forward_o   = right_fwd_q;
  assign standby_release_o = stby_out_q;
  assign running_o         = run_out_q;
  assign left_kicking_o    = left_kick_q;
  assign right_kicking_o   = right_kick_q;

`include "dual_motor_command_ramp_kick_core_assert.svh"

  `DMCRK_ASSERT_NEXT(a_disable_standby, pop_o && (cmd_i.op == FUNC_DISABLE), !stby_q && !run_q, "disable left standby or run set")
  `DMCRK_ASSERT_IMPL(a_left_duty_now, left_q.duty != '0, left_q.now != '0, "left duty without position")
  `DMCRK_ASSERT_IMPL(a_right_duty_now, right_q.duty != '0, right_q.now != '0, "right duty without position")

endmodule

FILE: src/dual_motor_command_ramp_kick_core.sv
// Top level of the two-channel motor command block with slew limit and kick-start.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------------
//  in      | in_valid_i / in_ready_o    | func_i, value_a_i, value_b_i
//  out     | out_valid_o / out_ready_i  | duties, directions, standby, running, kicking
//  cfg     | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// One request per cycle sustained while the output is taken; a result appears in the cycle
// after its command is taken from the two-entry queue by the back end.
// The back end retires one command per cycle while the result register is free or
// being taken; the queue absorbs two requests while the output stalls.
// Reset (rst_ni low, asynchronous) empties the queue, clears channel state and
// restores the register defaults; no clearing pass is needed.
module dual_motor_command_ramp_kick_core
  import dmcrk_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             func_i,
  input  logic signed [IN_W-1:0] value_a_i,
  input  logic signed [IN_W-1:0] value_b_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DUTY_W-1:0]      left_duty_o,
  output logic                   left_forward_o,
  output logic [DUTY_W-1:0]      right_duty_o,
  output logic                   right_forward_o,
  output logic                   standby_release_o,
  output logic                   running_o,
  output logic                   left_kicking_o,
  output logic                   right_kicking_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic fifo_full;
  logic fifo_empty;

  dmcrk_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmcrk_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_a_i   (value_a_i),
    .value_b_i   (value_b_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  dmcrk_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (pop_cmd)
  );

  dmcrk_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .fifo_empty_i      (fifo_empty),
    .cmd_i             (pop_cmd),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .left_duty_o       (left_duty_o),
    .left_forward_o    (left_forward_o),
    .right_duty_o      (right_duty_o),
    .right_forward_o   (right_forward_o),
    .standby_release_o (standby_release_o),
    .running_o         (running_o),
    .left_kicking_o    (left_kicking_o),
    .right_kicking_o   (right_kicking_o)
  );

endmodule
